// ===== rtl/frust_pkg.sv =====
// ----------------------------------------------------------------------------
// frust_pkg: shared types and constants for the frustum plane box cull block
// Opcode codes, arithmetic widths and the plane coefficient limits.
// ----------------------------------------------------------------------------
package frust_pkg;

  // Command codes carried in the opcode field of an input beat.
  typedef enum logic [1:0] {
    OP_LOAD_MV   = 2'd0,
    OP_LOAD_PROJ = 2'd1,
    OP_EXTRACT   = 2'd2,
    OP_TEST_BOX  = 2'd3
  } frust_op_t;

  localparam int ElemW  = 32;  // matrix element, Q16.16
  localparam int ClipW  = 50;  // clip element, 16 fraction bits
  localparam int PlaneW = 48;  // plane coefficient, 16 fraction bits
  localparam int CoordW = 33;  // box corner coordinate, Q17.16
  localparam int MulW   = 34;  // shared multiplier operand width
  localparam int ProdW  = 68;  // shared multiplier product width
  localparam int AccW   = 84;  // plane value accumulator, 32 fraction bits

  localparam logic signed [PlaneW-1:0] PlaneMax = {1'b0, {(PlaneW-1){1'b1}}};
  localparam logic signed [PlaneW-1:0] PlaneMin = {1'b1, {(PlaneW-1){1'b0}}};

endpackage

// ===== rtl/frust_in_if.sv =====
// ----------------------------------------------------------------------------
// frust_in_if: input channel of the frustum plane box cull block
// Carries one command beat: opcode, matrix element and box fields.
// ----------------------------------------------------------------------------
interface frust_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [3:0]         element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic signed [31:0] half_x;
  logic signed [31:0] half_y;
  logic signed [31:0] half_z;

  modport source (
    output valid, opcode, element_index, element_value,
    output center_x, center_y, center_z, half_x, half_y, half_z,
    input  ready
  );
  modport sink (
    input  valid, opcode, element_index, element_value,
    input  center_x, center_y, center_z, half_x, half_y, half_z,
    output ready
  );
endinterface

// ----------------------------------------------------------------------------
// frust_out_if: result channel of the frustum plane box cull block
// Carries the visibility flag of one box test.
// ----------------------------------------------------------------------------
interface frust_out_if;
  logic valid;
  logic ready;
  logic box_visible;

  modport source (output valid, box_visible, input ready);
  modport sink (input valid, box_visible, output ready);
endinterface

// ===== rtl/frustum_plane_box_cull.sv =====
// ----------------------------------------------------------------------------
// frustum_plane_box_cull: view frustum extraction and box culling
// Loads two matrices, extracts six planes and tests boxes against them.
// ----------------------------------------------------------------------------
// A load beat writes one element of its matrix. An extract beat forms the
// clip matrix (64 products through the one shared signed multiplier, each
// in a multiply state and an accumulate state) and then the 24 plane
// coefficients. A box test runs one term sequence per corner and plane
// (six partial products and the offset, each in a multiply and an
// accumulate state); a plane stops at its first corner in front, so from
// 6 sequences up to 48 in the worst case, and S_DONE then posts the result.
// The block accepts no beat while a command is in progress; a result beat
// waits in an output register.
module frustum_plane_box_cull (
  input logic         clk,
  input logic         rst,
  frust_in_if.sink    in_ch,
  frust_out_if.source out_ch
);
  import frust_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXT_MUL, S_EXT_ACC, S_PLANE, S_BOX_MUL, S_BOX_ACC, S_DONE
  } state_t;

  state_t state;

  logic signed [ElemW-1:0]  mv    [16];
  logic signed [ElemW-1:0]  proj  [16];
  logic signed [ClipW-1:0]  clip  [16];
  logic signed [PlaneW-1:0] plane [24];

  logic signed [CoordW-1:0] lo [3];
  logic signed [CoordW-1:0] hi [3];

  logic [5:0]               ext_cnt;   // {row, column, k}
  logic [4:0]               pl_cnt;    // {plane, coefficient}
  logic [2:0]               bp;        // plane under test
  logic [2:0]               cn;        // corner index
  logic [2:0]               tm;        // term within a corner
  logic signed [ClipW-1:0]  clip_acc;
  logic signed [AccW-1:0]   acc;
  logic signed [ProdW-1:0]  prod;
  logic                     visible;
  logic                     out_valid;
  logic                     out_bit;

  logic signed [MulW-1:0]   mul_a;
  logic signed [MulW-1:0]   mul_b;
  logic signed [PlaneW-1:0] coef;
  logic signed [CoordW-1:0] coord;
  logic [1:0]               tj;
  logic signed [ClipW-1:0]  floored;
  logic signed [ClipW-1:0]  clip_sum;
  logic signed [AccW-1:0]   term;
  logic signed [AccW-1:0]   acc_sum;
  logic signed [ClipW:0]    w_ext;
  logic signed [ClipW:0]    o_ext;
  logic signed [ClipW:0]    psum;
  logic signed [PlaneW-1:0] psat;
  logic                     plane_add;
  logic                     pos;

  assign in_ch.ready        = (state == S_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.box_visible = out_bit;

  // Shared multiplier operands: matrix elements during extract, one half of a
  // plane coefficient and one corner coordinate during a box test.
  always_comb begin
    tj    = tm[2:1];
    coef  = plane[{bp, tj}];
    unique case (tj)
      2'd0:    coord = cn[0] ? hi[0] : lo[0];
      2'd1:    coord = cn[1] ? hi[1] : lo[1];
      default: coord = cn[2] ? hi[2] : lo[2];
    endcase
    if (state == S_EXT_MUL) begin
      mul_a = MulW'(mv[{ext_cnt[5:4], ext_cnt[1:0]}]);
      mul_b = MulW'(proj[{ext_cnt[1:0], ext_cnt[3:2]}]);
    end else begin
      if (tm[0]) begin
        mul_a = MulW'($signed(coef[PlaneW-1:24]));
      end else begin
        mul_a = MulW'($signed({1'b0, coef[23:0]}));
      end
      mul_b = MulW'(coord);
    end
  end

  // Clip accumulation: the product floored to 16 fraction bits.
  assign floored  = ClipW'($signed(prod[63:16]));
  assign clip_sum = clip_acc + floored;

  // Plane value term: a partial product, the upper one weighted by 2^24,
  // or the offset coefficient scaled by 2^16.
  always_comb begin
    if (tm == 3'd6) begin
      term = {{(AccW-PlaneW-16){coef[PlaneW-1]}}, coef, 16'd0};
    end else if (tm[0]) begin
      term = AccW'(prod) <<< 24;
    end else begin
      term = AccW'(prod);
    end
    acc_sum = acc + term;
    pos     = !acc_sum[AccW-1] && (acc_sum != '0);
  end

  // Plane coefficient: sum or difference of two clip elements, saturated.
  always_comb begin
    w_ext     = (ClipW+1)'(clip[{pl_cnt[1:0], 2'd3}]);
    o_ext     = (ClipW+1)'(clip[{pl_cnt[1:0], pl_cnt[4:3]}]);
    plane_add = (pl_cnt[4:2] == 3'd1) || (pl_cnt[4:2] == 3'd2) || (pl_cnt[4:2] == 3'd5);
    psum      = plane_add ? (w_ext + o_ext) : (w_ext - o_ext);
    if (psum[ClipW:PlaneW-1] == '0 || psum[ClipW:PlaneW-1] == '1) begin
      psat = psum[PlaneW-1:0];
    end else if (psum[ClipW]) begin
      psat = PlaneMin;
    end else begin
      psat = PlaneMax;
    end
  end

  // Sequencer, stores and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      out_bit   <= 1'b0;
      ext_cnt   <= '0;
      pl_cnt    <= '0;
      bp        <= '0;
      cn        <= '0;
      tm        <= '0;
      visible   <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        mv[i]   <= '0;
        proj[i] <= '0;
      end
      for (int i = 0; i < 24; i++) begin
        plane[i] <= '0;
      end
    end else begin
      if (out_valid && out_ch.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      prod <= mul_a * mul_b;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            unique case (frust_op_t'(in_ch.opcode))
              OP_LOAD_MV:   mv[in_ch.element_index]   <= in_ch.element_value;
              OP_LOAD_PROJ: proj[in_ch.element_index] <= in_ch.element_value;
              OP_EXTRACT: begin
                ext_cnt  <= '0;
                clip_acc <= '0;
                state    <= S_EXT_MUL;
              end
              OP_TEST_BOX: begin
                lo[0] <= CoordW'(in_ch.center_x) - CoordW'(in_ch.half_x);
                hi[0] <= CoordW'(in_ch.center_x) + CoordW'(in_ch.half_x);
                lo[1] <= CoordW'(in_ch.center_y) - CoordW'(in_ch.half_y);
                hi[1] <= CoordW'(in_ch.center_y) + CoordW'(in_ch.half_y);
                lo[2] <= CoordW'(in_ch.center_z) - CoordW'(in_ch.half_z);
                hi[2] <= CoordW'(in_ch.center_z) + CoordW'(in_ch.half_z);
                bp    <= '0;
                cn    <= '0;
                tm    <= '0;
                acc   <= '0;
                state <= S_BOX_MUL;
              end
              default: ;
            endcase
          end
        end
        S_EXT_MUL: state <= S_EXT_ACC;
        S_EXT_ACC: begin
          if (ext_cnt[1:0] == 2'd3) begin
            clip[ext_cnt[5:2]] <= clip_sum;
            clip_acc           <= '0;
          end else begin
            clip_acc <= clip_sum;
          end
          ext_cnt <= ext_cnt + 6'd1;
          if (ext_cnt == 6'd63) begin
            pl_cnt <= '0;
            state  <= S_PLANE;
          end else begin
            state <= S_EXT_MUL;
          end
        end
        S_PLANE: begin
          plane[pl_cnt] <= psat;
          pl_cnt        <= pl_cnt + 5'd1;
          if (pl_cnt == 5'd23) begin
            state <= S_IDLE;
          end
        end
        S_BOX_MUL: state <= S_BOX_ACC;
        S_BOX_ACC: begin
          if (tm != 3'd6) begin
            acc   <= acc_sum;
            tm    <= tm + 3'd1;
            state <= S_BOX_MUL;
          end else begin
            acc <= '0;
            tm  <= '0;
            if (pos) begin
              // A corner lies in front: this plane cannot cull the box.
              cn <= '0;
              if (bp == 3'd5) begin
                visible <= 1'b1;
                state   <= S_DONE;
              end else begin
                bp    <= bp + 3'd1;
                state <= S_BOX_MUL;
              end
            end else if (cn == 3'd7) begin
              visible <= 1'b0;
              state   <= S_DONE;
            end else begin
              cn    <= cn + 3'd1;
              state <= S_BOX_MUL;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_bit   <= visible;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/frustum_plane_box_cull_test.sv =====
// ----------------------------------------------------------------------------
// frustum_plane_box_cull_test: self-checking regression for the cull block
// Loads matrices, extracts planes and tests boxes through the command
// channel. A built-in fixed-point predictor computes the visibility that
// each box test should report. The run goes through phases of random idling
// on both channels, a long result stall, and drains between phases.
// ----------------------------------------------------------------------------
module frustum_plane_box_cull_test;
  import frust_pkg::*;

  localparam int IdleLimit  = 20000;  // cycles with no beat on either channel
  localparam int DrainWait  = 900;    // longest command, extract or box test
  localparam int LongHold   = 3000;   // long result stall, in cycles
  localparam int PhaseItems = 210;

  typedef struct {
    frust_op_t          op;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] cx, cy, cz, hx, hy, hz;
  } cull_cmd_t;

  logic clk;
  logic rst;

  frust_in_if  in_ch();
  frust_out_if out_ch();

  frustum_plane_box_cull dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Commands waiting to be sent, and visibility flags waiting to arrive.
  cull_cmd_t cmd_queue[$];
  logic      visible_queue[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen;
  int hold_left;
  int cmds_queued    = 0;
  int cmds_taken     = 0;
  int errors         = 0;
  int quiet_cycles;

  // Predictor state: both matrices and the plane coefficients.
  logic signed [31:0] mv_mat[16];
  logic signed [31:0] proj_mat[16];
  logic signed [47:0] planes[24];

  // Clock: period 10.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Clip matrix from the two matrices, then six planes from its columns.
  function automatic void form_planes();
    logic signed [63:0] clip[16];
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    logic signed [63:0] w;
    logic signed [63:0] o;
    logic signed [63:0] t;
    int col_of[6];
    int add_of[6];
    col_of = '{0, 0, 1, 1, 2, 2};
    add_of = '{0, 1, 1, 0, 0, 1};
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          prod = 64'(mv_mat[r*4+k]) * 64'(proj_mat[k*4+c]);
          acc = acc + (prod >>> 16);
        end
        clip[r*4+c] = acc;
      end
    end
    for (int p = 0; p < 6; p++) begin
      for (int j = 0; j < 4; j++) begin
        w = clip[j*4+3];
        o = clip[j*4+col_of[p]];
        t = add_of[p] ? w + o : w - o;
        if (t > 64'(PlaneMax)) t = 64'(PlaneMax);
        if (t < 64'(PlaneMin)) t = 64'(PlaneMin);
        planes[p*4+j] = t[47:0];
      end
    end
  endfunction

  // A box is hidden when some plane has all eight corners at or below zero.
  function automatic logic box_in_view(cull_cmd_t b);
    logic signed [127:0] lo[3];
    logic signed [127:0] hi[3];
    logic signed [127:0] v;
    logic signed [127:0] ctr[3];
    logic signed [127:0] hlf[3];
    logic any_front;
    ctr = '{128'(b.cx), 128'(b.cy), 128'(b.cz)};
    hlf = '{128'(b.hx), 128'(b.hy), 128'(b.hz)};
    for (int j = 0; j < 3; j++) begin
      lo[j] = ctr[j] - hlf[j];
      hi[j] = ctr[j] + hlf[j];
    end
    for (int p = 0; p < 6; p++) begin
      any_front = 1'b0;
      for (int n = 0; n < 8; n++) begin
        v = 128'(planes[p*4+3]) <<< 16;
        for (int j = 0; j < 3; j++)
          v = v + 128'(planes[p*4+j]) * (n[j] ? hi[j] : lo[j]);
        if (v > 0) any_front = 1'b1;
      end
      if (!any_front) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Matrix element: mostly small values, some extremes, some full range.
  function automatic logic signed [31:0] pick_elem();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 32'(int'($urandom_range(0, 6 * 65536)) - 3 * 65536);
    if (r < 80) return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
    if (r < 85) return 32'(int'($urandom_range(0, 2)) - 1);
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_center();
    if ($urandom_range(9) < 8) return 32'(int'($urandom_range(0, 16 * 65536)) - 8 * 65536);
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_half();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 32'($urandom_range(0, 2 * 65536));
    if (r < 8) return 32'(-int'($urandom_range(0, 2 * 65536)));
    return $urandom;
  endfunction

  // Command with every field random; unused fields carry noise.
  function automatic cull_cmd_t noise_cmd(frust_op_t op);
    cull_cmd_t c;
    c.op  = op;
    c.idx = 4'($urandom);
    c.val = $urandom;
    c.cx  = $urandom;
    c.cy  = $urandom;
    c.cz  = $urandom;
    c.hx  = $urandom;
    c.hy  = $urandom;
    c.hz  = $urandom;
    return c;
  endfunction

  task automatic push_cmd(cull_cmd_t c);
    cmd_queue.push_back(c);
    cmds_queued++;
  endtask

  task automatic push_load(frust_op_t op, int idx, logic signed [31:0] val);
    cull_cmd_t c;
    c = noise_cmd(op);
    c.idx = 4'(idx);
    c.val = val;
    push_cmd(c);
  endtask

  task automatic push_box(logic signed [31:0] cx, cy, cz, hx, hy, hz);
    cull_cmd_t c;
    c = noise_cmd(OP_TEST_BOX);
    c.cx = cx; c.cy = cy; c.cz = cz;
    c.hx = hx; c.hy = hy; c.hz = hz;
    push_cmd(c);
  endtask

  // Full scene: both matrices in shuffled order, extract, then boxes.
  task automatic push_scene();
    int order[16];
    int nbox;
    for (int i = 0; i < 16; i++) order[i] = i;
    order.shuffle();
    for (int i = 0; i < 16; i++) push_load(OP_LOAD_MV, order[i], pick_elem());
    order.shuffle();
    for (int i = 0; i < 16; i++) push_load(OP_LOAD_PROJ, order[i], pick_elem());
    push_cmd(noise_cmd(OP_EXTRACT));
    nbox = $urandom_range(6, 14);
    for (int i = 0; i < nbox; i++)
      push_box(pick_center(), pick_center(), pick_center(),
               pick_half(), pick_half(), pick_half());
  endtask

  task automatic push_random_phase(int count);
    int start;
    start = cmds_queued;
    while (cmds_queued - start < count) begin
      if ($urandom_range(99) < 80) begin
        push_scene();
      end else begin
        for (int i = 0; i < 6; i++)
          push_cmd(noise_cmd(frust_op_t'($urandom_range(3))));
      end
    end
  endtask

  // Wait until every command is taken and every result has come.
  task automatic drain();
    while (cmds_taken != cmds_queued || visible_queue.size() != 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Command driver.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cull_cmd_t c;
        c = cmd_queue.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= c.op;
        in_ch.element_index <= c.idx;
        in_ch.element_value <= c.val;
        in_ch.center_x      <= c.cx;
        in_ch.center_y      <= c.cy;
        in_ch.center_z      <= c.cz;
        in_ch.half_x        <= c.hx;
        in_ch.half_y        <= c.hy;
        in_ch.half_z        <= c.hz;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= LongHold;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Command monitor: update the predictor on each accepted beat.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      cull_cmd_t c;
      c.op  = frust_op_t'(in_ch.opcode);
      c.idx = in_ch.element_index;
      c.val = in_ch.element_value;
      c.cx  = in_ch.center_x;
      c.cy  = in_ch.center_y;
      c.cz  = in_ch.center_z;
      c.hx  = in_ch.half_x;
      c.hy  = in_ch.half_y;
      c.hz  = in_ch.half_z;
      cmds_taken++;
      case (c.op)
        OP_LOAD_MV:   mv_mat[c.idx] = c.val;
        OP_LOAD_PROJ: proj_mat[c.idx] = c.val;
        OP_EXTRACT:   form_planes();
        OP_TEST_BOX:  visible_queue.push_back(box_in_view(c));
        default: ;
      endcase
    end
  end

  // Result monitor: compare each beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (visible_queue.size() == 0) begin
        $display("%0t: unexpected result beat, box_visible %b", $time,
                 out_ch.box_visible);
        errors++;
      end else begin
        logic want;
        want = visible_queue.pop_front();
        if (out_ch.box_visible !== want) begin
          $display("%0t: box_visible mismatch, expected %b, actual %b", $time,
                   want, out_ch.box_visible);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("frustum_plane_box_cull regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    phase_idle  = '{0, 80, 0, 24};
    phase_stall = '{0, 0, 80, 24};
    for (int i = 0; i < 16; i++) begin
      mv_mat[i]   = '0;
      proj_mat[i] = '0;
    end
    for (int i = 0; i < 24; i++) planes[i] = '0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_LOAD_MV;
    in_ch.element_index = '0;
    in_ch.element_value = '0;
    in_ch.center_x      = '0;
    in_ch.center_y      = '0;
    in_ch.center_z      = '0;
    in_ch.half_x        = '0;
    in_ch.half_y        = '0;
    in_ch.half_z        = '0;
    out_ch.ready        = 1'b0;
    quiet_cycles        = 0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero planes after reset hide every box, then extremes.
    push_box(32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h7fffffff, 32'h7fffffff, 32'h80000000);
    push_load(OP_LOAD_MV, 0, 32'h7fffffff);
    push_load(OP_LOAD_MV, 15, 32'h80000000);
    push_load(OP_LOAD_PROJ, 0, 32'h80000000);
    push_load(OP_LOAD_PROJ, 15, 32'h7fffffff);
    push_cmd(noise_cmd(OP_EXTRACT));
    push_box(0, 0, 0, 0, 0, 0);
    push_box(32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h80000000, 32'h80000000);
    // Near-identity matrices; proj element 15 still holds 32'h7fffffff, so the frustum is wide.
    for (int i = 0; i < 4; i++) push_load(OP_LOAD_MV, i * 5, 32'sd65536);
    push_load(OP_LOAD_PROJ, 0, 32'sd65536);
    push_load(OP_LOAD_PROJ, 5, 32'sd65536);
    push_load(OP_LOAD_PROJ, 10, 32'sd65536);
    push_cmd(noise_cmd(OP_EXTRACT));
    push_box(0, 0, 0, 32'sd16384, 32'sd16384, 32'sd16384);
    push_box(32'sd655360, 0, 0, 32'sd16384, 32'sd16384, 32'sd16384);
    // Negative half extents describe the same box.
    push_box(32'sd655360, 0, 0, -32'sd16384, -32'sd16384, -32'sd16384);
    push_box(32'sd98304, 0, 0, -32'sd65536, 32'sd65536, -32'sd65536);
    push_box(0, 0, 32'sd131072, 32'sd1, 32'sd1, 32'sd1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      push_random_phase(PhaseItems);
      // A long result stall while commands keep coming.
      if (ph == 0) hold_token++;
      drain();
    end

    if (errors == 0) begin
      $display("frustum_plane_box_cull regression: pass");
    end else begin
      $display("frustum_plane_box_cull regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/frust_pkg.sv
rtl/frust_in_if.sv
rtl/frustum_plane_box_cull.sv
tb/frustum_plane_box_cull_test.sv
